[sv/mme_pkg.sv]
package mme_pkg;

    // Default operand width and the modulus value after reset.
    localparam int WIDTH_DEFAULT = 64;
    localparam int FIELD_W       = 64;
    localparam logic [FIELD_W-1:0] MODULUS_RESET = 64'd1;

endpackage

[sv/modular_exponentiation.sv]
// A modular multiplication doubles its accumulator for each bit of its second operand and adds
// once more for each set bit; a start strobe and a done strobe frame it. An item needs one base
// reduction, a scan past the leading zero exponent bits, a square per bit from the top set bit,
// a multiply per set bit, and a final register for the result.
// Throughput: one item at a time; the next item is taken once the result has been registered.
// Reset: aresetn is synchronous, active low; it clears control state and sets the modulus to 1.
module modular_exponentiation #(
    parameter int WIDTH = mme_pkg::WIDTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_cfg_valid,
    output logic        s_cfg_ready,
    input  logic [63:0] s_cfg_modulus,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_base_value,
    input  logic [63:0] s_exponent_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_power_residue
);

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_BRED, ST_SCAN, ST_SQR, ST_MUL, ST_FIN
    } state_t;

    state_t           state_reg;
    logic [WIDTH-1:0] mod_reg;
    logic [WIDTH-1:0] e_reg;
    logic [WIDTH-1:0] r_reg;
    logic [WIDTH-1:0] bred_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;
    logic             start_reg;
    logic [WIDTH-1:0] op_a_reg;
    logic [WIDTH-1:0] op_b_reg;
    logic             out_valid_reg;
    logic [WIDTH-1:0] out_reg;

    logic             mul_done;
    logic [WIDTH-1:0] mul_result;
    logic [WIDTH-1:0] one_mod;
    logic [WIDTH-1:0] base_raw;
    logic             out_free;

    assign one_mod  = (mod_reg == WIDTH'(1)) ? '0 : WIDTH'(1);
    assign base_raw = s_base_value[WIDTH-1:0];
    assign out_free = !out_valid_reg || m_ready;

    mme_mulmod #(.WIDTH(WIDTH)) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .op_a    (op_a_reg),
        .op_b    (op_b_reg),
        .modulus (mod_reg),
        .done    (mul_done),
        .result  (mul_result)
    );

    // Configuration register: always ready, taken on each transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mod_reg <= mme_pkg::MODULUS_RESET[WIDTH-1:0];
        end else if (s_cfg_valid) begin
            mod_reg <= s_cfg_modulus[WIDTH-1:0];
        end
    end

    // Sequencer: reduce the base, skip leading zero bits, then square and multiply; a zero modulus yields zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            start_reg <= 1'b0;
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        e_reg   <= s_exponent_value[WIDTH-1:0];
                        neg_reg <= base_raw[WIDTH-1];
                        cnt_reg <= CNT_W'(WIDTH - 1);
                        if (mod_reg == '0) begin
                            r_reg     <= '0;
                            state_reg <= ST_FIN;
                        end else begin
                            // Reduce the base magnitude as 1 * magnitude mod m.
                            op_a_reg  <= one_mod;
                            op_b_reg  <= base_raw[WIDTH-1] ? (~base_raw + 1'b1) : base_raw;
                            start_reg <= 1'b1;
                            state_reg <= ST_BRED;
                        end
                    end
                end
                ST_BRED: begin
                    if (mul_done) begin
                        if (neg_reg && mul_result != '0) begin
                            bred_reg <= mod_reg - mul_result;
                        end else begin
                            bred_reg <= mul_result;
                        end
                        r_reg     <= one_mod;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (e_reg[WIDTH-1] || cnt_reg == '0) begin
                        op_a_reg  <= r_reg;
                        op_b_reg  <= r_reg;
                        start_reg <= 1'b1;
                        state_reg <= ST_SQR;
                    end else begin
                        e_reg   <= e_reg << 1;
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                ST_SQR: begin
                    if (mul_done) begin
                        r_reg <= mul_result;
                        if (e_reg[WIDTH-1]) begin
                            op_a_reg  <= mul_result;
                            op_b_reg  <= bred_reg;
                            start_reg <= 1'b1;
                            state_reg <= ST_MUL;
                        end else if (cnt_reg == '0) begin
                            state_reg <= ST_FIN;
                        end else begin
                            e_reg     <= e_reg << 1;
                            cnt_reg   <= cnt_reg - 1'b1;
                            op_a_reg  <= mul_result;
                            op_b_reg  <= mul_result;
                            start_reg <= 1'b1;
                        end
                    end
                end
                ST_MUL: begin
                    if (mul_done) begin
                        r_reg <= mul_result;
                        if (cnt_reg == '0) begin
                            state_reg <= ST_FIN;
                        end else begin
                            e_reg     <= e_reg << 1;
                            cnt_reg   <= cnt_reg - 1'b1;
                            op_a_reg  <= mul_result;
                            op_b_reg  <= mul_result;
                            start_reg <= 1'b1;
                            state_reg <= ST_SQR;
                        end
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        out_reg       <= r_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_cfg_ready     = 1'b1;
    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = out_valid_reg;
    assign m_power_residue = 64'(out_reg);

endmodule

[sv/mme_cell.sv]
module mme_cell (
    input  logic x_bit,
    input  logic y_bit,
    input  logic m_bit,
    input  logic carry_in,
    input  logic borrow_in,
    output logic sum_bit,
    output logic diff_bit,
    output logic carry_out,
    output logic borrow_out
);

    // One bit of the sum x + y, and one bit of that sum minus the modulus.
    assign sum_bit    = x_bit ^ y_bit ^ carry_in;
    assign carry_out  = (x_bit & y_bit) | (carry_in & (x_bit ^ y_bit));
    assign diff_bit   = sum_bit ^ m_bit ^ borrow_in;
    assign borrow_out = (~sum_bit & m_bit) | (~(sum_bit ^ m_bit) & borrow_in);

endmodule

[sv/mme_mulmod.sv]
module mme_mulmod #(
    parameter int WIDTH = mme_pkg::WIDTH_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] op_a,
    input  logic [WIDTH-1:0] op_b,
    input  logic [WIDTH-1:0] modulus,
    output logic             done,
    output logic [WIDTH-1:0] result
);

    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0] r_reg, r_next;
    logic [WIDTH-1:0] a_reg;
    logic [WIDTH-1:0] b_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             phase_reg;
    logic             done_reg;

    logic [WIDTH-1:0] add_y;
    logic [WIDTH-1:0] sum_vec;
    logic [WIDTH-1:0] diff_vec;
    logic [WIDTH:0]   carry_vec;
    logic [WIDTH:0]   borrow_vec;

    // The second addend is the accumulator when doubling, the multiplicand when adding.
    assign add_y         = phase_reg ? a_reg : r_reg;
    assign carry_vec[0]  = 1'b0;
    assign borrow_vec[0] = 1'b0;

    // Row of bit cells: the carry and borrow ripple from each cell to its neighbor.
    for (genvar i = 0; i < WIDTH; i++) begin : g_cell
        mme_cell u_cell (
            .x_bit      (r_reg[i]),
            .y_bit      (add_y[i]),
            .m_bit      (modulus[i]),
            .carry_in   (carry_vec[i]),
            .borrow_in  (borrow_vec[i]),
            .sum_bit    (sum_vec[i]),
            .diff_bit   (diff_vec[i]),
            .carry_out  (carry_vec[i+1]),
            .borrow_out (borrow_vec[i+1])
        );
    end

    // Subtract the modulus when the sum overflowed or reached it.
    assign r_next = (carry_vec[WIDTH] || !borrow_vec[WIDTH]) ? diff_vec : sum_vec;

    // Double the accumulator for each multiplier bit, then add when the bit is set.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg) begin
                if (start) begin
                    busy_reg  <= 1'b1;
                    phase_reg <= 1'b0;
                    cnt_reg   <= CNT_W'(WIDTH - 1);
                    r_reg     <= '0;
                    a_reg     <= op_a;
                    b_reg     <= op_b;
                end
            end else begin
                r_reg <= r_next;
                if (!phase_reg && b_reg[WIDTH-1]) begin
                    phase_reg <= 1'b1;
                end else begin
                    phase_reg <= 1'b0;
                    b_reg     <= b_reg << 1;
                    if (cnt_reg == '0) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

[sv/mme_checker.sv]
module mme_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [63:0] m_power_residue
);

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_power_residue))
        else $error("result changed while stalled");

    // After an input transfer the block is busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while busy");

    // No result is offered right after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A new result only appears as the block becomes ready for the next input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result appeared outside completion");

endmodule

bind modular_exponentiation mme_checker u_mme_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_power_residue (m_power_residue)
);
